// ===== sv/mu8je_pkg.sv =====
// shared types and constants for the modified utf-8 to json escape block
`timescale 1ns / 1ps

package mu8je_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam int          MAX_UNITS   = 3;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bytes held of an unfinished sequence
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } pend_t;

    // how a unit is written as text
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_HEX   = 2'd2
    } kind_t;

    // decoded units of one input byte
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [1:0]                 unit_cnt;
        logic                       str_end;
    } unit_rec_t;

endpackage

// ===== sv/modified_utf8_to_json_escape.sv =====
// top level of the modified utf-8 to json escaped text converter
`timescale 1ns / 1ps

// One raw byte is taken per cycle while the four-entry queue of decoded
// units has room; the decoder holds at most two bytes of an unfinished
// sequence. The text writer delivers one escaped character per cycle while
// the reader keeps popping, and a byte yields as many characters as it
// causes: none for a held lead byte, one for printable ASCII, two for a
// short escape, six for each \uXXXX escape, up to eighteen when a broken
// sequence is flushed. Sustained rate is therefore set by the text writer
// and the reader; input stalls (full high) only once the unit queue fills.

module modified_utf8_to_json_escape
    import mu8je_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       string_end,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] out_char,
    output logic       run_last,
    output logic       text_end
);

    logic      accept;
    logic      rec_push;
    unit_rec_t rec_in;
    unit_rec_t rec_out;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    mu8je_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .string_end (string_end),
        .rec_push   (rec_push),
        .rec        (rec_in)
    );

    mu8je_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (rec_out),
        .empty   (q_empty)
    );

    mu8je_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (rec_out),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_char (out_char),
        .run_last (run_last),
        .text_end (text_end)
    );

endmodule

// ===== sv/mu8je_front.sv =====
// byte decoder: tracks pending sequence bytes and emits decoded units
`timescale 1ns / 1ps

module mu8je_front
    import mu8je_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        string_end,
    output logic        rec_push,
    output unit_rec_t   rec
);

    pend_t       pend_reg, pend_next;
    logic [7:0]  lead_reg, lead_next;
    logic [7:0]  cont_reg, cont_next;

    logic                       is_cont;
    logic                       is_lead;
    logic                       restart;
    logic [1:0]                 ucnt;
    logic [MAX_UNITS-1:0][15:0] units;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            lead_reg <= 8'h00;
            cont_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            lead_reg <= lead_next;
            cont_reg <= cont_next;
        end
    end

    always_comb
    begin
        is_cont   = (in_byte[7:6] == 2'b10);
        is_lead   = (in_byte[7:5] == 3'b110) || (in_byte[7:4] == 4'b1110);
        restart   = 1'b0;
        ucnt      = 2'd0;
        units     = {MAX_UNITS{REPL_UNIT}};
        pend_next = pend_reg;
        lead_next = lead_reg;
        cont_next = cont_reg;

        unique case (pend_reg)
            PEND_ONE:
            begin
                if (is_cont)
                begin
                    if (lead_reg[7:5] == 3'b110)
                    begin
                        units[ucnt] = {5'b0, lead_reg[4:0], in_byte[5:0]};
                        ucnt        = ucnt + 2'd1;
                        pend_next   = PEND_NONE;
                    end
                    else
                    begin
                        cont_next = in_byte;
                        pend_next = PEND_TWO;
                    end
                end
                else
                begin
                    units[ucnt] = REPL_UNIT;
                    ucnt        = ucnt + 2'd1;
                    pend_next   = PEND_NONE;
                    restart     = 1'b1;
                end
            end
            PEND_TWO:
            begin
                if (is_cont)
                begin
                    units[ucnt] = {lead_reg[3:0], cont_reg[5:0], in_byte[5:0]};
                    ucnt        = ucnt + 2'd1;
                    pend_next   = PEND_NONE;
                end
                else
                begin
                    units[ucnt] = REPL_UNIT;
                    ucnt        = ucnt + 2'd1;
                    units[ucnt] = REPL_UNIT;
                    ucnt        = ucnt + 2'd1;
                    pend_next   = PEND_NONE;
                    restart     = 1'b1;
                end
            end
            default:
            begin
                pend_next = PEND_NONE;
                restart   = 1'b1;
            end
        endcase

        // fresh lead byte
        if (restart)
        begin
            if (!in_byte[7])
            begin
                units[ucnt] = {8'h00, in_byte};
                ucnt        = ucnt + 2'd1;
            end
            else if (is_lead)
            begin
                lead_next = in_byte;
                pend_next = PEND_ONE;
            end
            else
            begin
                units[ucnt] = REPL_UNIT;
                ucnt        = ucnt + 2'd1;
            end
        end

        // flush at end of string
        if (string_end)
        begin
            if (pend_next == PEND_ONE)
            begin
                units[ucnt] = REPL_UNIT;
                ucnt        = ucnt + 2'd1;
            end
            else if (pend_next == PEND_TWO)
            begin
                units[ucnt] = REPL_UNIT;
                ucnt        = ucnt + 2'd1;
                units[ucnt] = REPL_UNIT;
                ucnt        = ucnt + 2'd1;
            end
            pend_next = PEND_NONE;
        end
    end

    assign rec.units    = units;
    assign rec.unit_cnt = ucnt;
    assign rec.str_end  = string_end;
    assign rec_push     = accept && (ucnt != 2'd0);

    pend_never_three: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("pending count reached an unused code");

    end_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && string_end) |=> (pend_reg == PEND_NONE))
        else $error("bytes still pending after end of string");

endmodule

// ===== sv/mu8je_fifo.sv =====
// small queue of decoded unit records between decoder and text writer
`timescale 1ns / 1ps

module mu8je_fifo
    import mu8je_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  unit_rec_t  wr_data,
    output logic       full,
    input  logic       rd_en,
    output unit_rec_t  rd_data,
    output logic       empty
);

    unit_rec_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

    assign full    = (cnt_reg == DEPTH_CNT);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("record written into a full queue");

    no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("record read from an empty queue");

endmodule

// ===== sv/mu8je_back.sv =====
// text writer: expands each decoded unit into escaped json characters
`timescale 1ns / 1ps

module mu8je_back
    import mu8je_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  unit_rec_t  q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] out_char,
    output logic       run_last,
    output logic       text_end
);

    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_U      = 7'h75;

    logic [1:0] ui_reg, ui_next;
    logic [2:0] ci_reg, ci_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       rlast_reg, rlast_next;
    logic       tend_reg, tend_next;

    logic [15:0] unit;
    kind_t       kind;
    logic [6:0]  short_ch;
    logic [2:0]  last_ci;
    logic [3:0]  nib;
    logic [6:0]  cur_ch;
    logic        unit_done;
    logic        rec_done;
    logic        advance;

    always_comb
    begin
        unit     = q_data.units[ui_reg];
        short_ch = 7'h00;
        kind     = KIND_HEX;
        case (unit)
            16'h0022: short_ch = 7'h22;
            16'h005C: short_ch = 7'h5C;
            16'h0008: short_ch = 7'h62;
            16'h000C: short_ch = 7'h66;
            16'h000A: short_ch = 7'h6E;
            16'h000D: short_ch = 7'h72;
            16'h0009: short_ch = 7'h74;
            default:  short_ch = 7'h00;
        endcase
        if (short_ch != 7'h00)
        begin
            kind = KIND_SHORT;
        end
        else if (unit >= 16'h0020 && unit < 16'h007F)
        begin
            kind = KIND_PLAIN;
        end

        case (ci_reg)
            3'd2:    nib = unit[15:12];
            3'd3:    nib = unit[11:8];
            3'd4:    nib = unit[7:4];
            default: nib = unit[3:0];
        endcase

        cur_ch  = CH_BSLASH;
        last_ci = 3'd5;
        unique case (kind)
            KIND_PLAIN:
            begin
                cur_ch  = unit[6:0];
                last_ci = 3'd0;
            end
            KIND_SHORT:
            begin
                cur_ch  = (ci_reg == 3'd0) ? CH_BSLASH : short_ch;
                last_ci = 3'd1;
            end
            default:
            begin
                last_ci = 3'd5;
                if (ci_reg == 3'd0)
                begin
                    cur_ch = CH_BSLASH;
                end
                else if (ci_reg == 3'd1)
                begin
                    cur_ch = CH_U;
                end
                else if (nib < 4'd10)
                begin
                    cur_ch = 7'h30 + {3'b000, nib};
                end
                else
                begin
                    cur_ch = 7'h57 + {3'b000, nib};
                end
            end
        endcase

        unit_done = (ci_reg == last_ci);
        rec_done  = unit_done && (ui_reg == q_data.unit_cnt - 2'd1);
        advance   = !q_empty && (!valid_reg || pop);
        q_pop     = advance && rec_done;

        ui_next    = ui_reg;
        ci_next    = ci_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        rlast_next = rlast_reg;
        tend_next  = tend_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            char_next  = cur_ch;
            rlast_next = rec_done;
            tend_next  = rec_done && q_data.str_end;
            if (!unit_done)
            begin
                ci_next = ci_reg + 3'd1;
            end
            else
            begin
                ci_next = 3'd0;
                ui_next = rec_done ? 2'd0 : ui_reg + 2'd1;
            end
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ui_reg    <= 2'd0;
            ci_reg    <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ui_reg    <= ui_next;
            ci_reg    <= ci_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        rlast_reg <= rlast_next;
        tend_reg  <= tend_next;
    end

    assign empty    = !valid_reg;
    assign out_char = char_reg;
    assign run_last = rlast_reg;
    assign text_end = tend_reg;

    char_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ci_reg <= 3'd5)
        else $error("character index out of range");

    pop_restarts_record: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (ui_reg == 2'd0 && ci_reg == 3'd0 && run_last))
        else $error("record retired without a final character");

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the modified utf-8 to json escape converter
`timescale 1ns / 1ps

module tb;
    import mu8je_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_SETTLE    = 12;
    localparam int TAIL_CYCLES    = 40;
    localparam int RANDOM_BYTES   = 300;

    localparam logic [6:0] CH_QUOTE = 7'h22;
    localparam logic [6:0] CH_BSL   = 7'h5C;
    localparam logic [6:0] CH_B     = 7'h62;
    localparam logic [6:0] CH_F     = 7'h66;
    localparam logic [6:0] CH_N     = 7'h6E;
    localparam logic [6:0] CH_R     = 7'h72;
    localparam logic [6:0] CH_T     = 7'h74;
    localparam logic [6:0] CH_U     = 7'h75;

    localparam logic [15:0] U_QUOTE = 16'h0022;
    localparam logic [15:0] U_BSL   = 16'h005C;
    localparam logic [15:0] U_BS    = 16'h0008;
    localparam logic [15:0] U_FF    = 16'h000C;
    localparam logic [15:0] U_LF    = 16'h000A;
    localparam logic [15:0] U_CR    = 16'h000D;
    localparam logic [15:0] U_TAB   = 16'h0009;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       fin;
    } txt_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       hold;
        logic       rush;
    } byte_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_byte = 8'h00;
    logic       string_end = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [6:0] out_char;
    logic       run_last;
    logic       text_end;

    byte_item_t byte_q[$];
    txt_t       want_text[$];
    txt_t       step_text[$];

    pend_t      dec_pend = PEND_NONE;
    logic [7:0] dec_lead = 8'h00;
    logic [7:0] dec_cont = 8'h00;

    int  errors = 0;
    int  bytes_sent = 0;
    int  strings_sent = 0;
    int  chars_seen = 0;
    int  max_step = 0;
    int  holds_done = 0;
    int  send_gap = 0;
    int  settle = 0;
    int  pop_gap = 0;
    int  stall = 0;
    logic holding = 1'b0;
    logic pop_rush = 1'b0;

    modified_utf8_to_json_escape DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_byte    (in_byte),
        .string_end (string_end),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .run_last   (run_last),
        .text_end   (text_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [6:0] hex_digit(logic [3:0] n);
        if (n < 4'd10)
            return 7'h30 + n;
        else
            return 7'h57 + n;
    endfunction

    function void put_ch(logic [6:0] c);
        step_text.push_back('{c, 1'b0, 1'b0});
    endfunction

    function void put_unit(logic [15:0] u);
        logic [6:0] esc;
        esc = '0;
        case (u)
            U_QUOTE: esc = CH_QUOTE;
            U_BSL:   esc = CH_BSL;
            U_BS:    esc = CH_B;
            U_FF:    esc = CH_F;
            U_LF:    esc = CH_N;
            U_CR:    esc = CH_R;
            U_TAB:   esc = CH_T;
            default: esc = '0;
        endcase
        if (esc != '0)
        begin
            put_ch(CH_BSL);
            put_ch(esc);
        end
        else if (u >= 16'h0020 && u < 16'h007F)
            put_ch(u[6:0]);
        else
        begin
            put_ch(CH_BSL);
            put_ch(CH_U);
            for (int k = 3; k >= 0; k--)
                put_ch(hex_digit(u[k*4 +: 4]));
        end
    endfunction

    function void take_lead(logic [7:0] b);
        if (b < 8'h80)
            put_unit({8'h00, b});
        else if ((b & 8'hE0) == 8'hC0 || (b & 8'hF0) == 8'hE0)
        begin
            dec_lead = b;
            dec_pend = PEND_ONE;
        end
        else
            put_unit(REPL_UNIT);
    endfunction

    // decode one byte and queue the escaped text it causes
    function void escape_predict(logic [7:0] b, logic fin);
        logic is_cont;
        is_cont = (b & 8'hC0) == 8'h80;
        step_text.delete();
        case (dec_pend)
            PEND_ONE:
                if (is_cont && (dec_lead & 8'hE0) == 8'hC0)
                begin
                    put_unit({5'b0, dec_lead[4:0], b[5:0]});
                    dec_pend = PEND_NONE;
                end
                else if (is_cont)
                begin
                    dec_cont = b;
                    dec_pend = PEND_TWO;
                end
                else
                begin
                    put_unit(REPL_UNIT);
                    dec_pend = PEND_NONE;
                    take_lead(b);
                end
            PEND_TWO:
                if (is_cont)
                begin
                    put_unit({dec_lead[3:0], dec_cont[5:0], b[5:0]});
                    dec_pend = PEND_NONE;
                end
                else
                begin
                    put_unit(REPL_UNIT);
                    put_unit(REPL_UNIT);
                    dec_pend = PEND_NONE;
                    take_lead(b);
                end
            default:
            begin
                dec_pend = PEND_NONE;
                take_lead(b);
            end
        endcase
        if (fin)
        begin
            if (dec_pend == PEND_ONE)
                put_unit(REPL_UNIT);
            else if (dec_pend == PEND_TWO)
            begin
                put_unit(REPL_UNIT);
                put_unit(REPL_UNIT);
            end
            dec_pend = PEND_NONE;
        end
        if (step_text.size() > 0)
        begin
            step_text[step_text.size()-1].last = 1'b1;
            step_text[step_text.size()-1].fin  = fin;
        end
        if (step_text.size() > max_step)
            max_step = step_text.size();
        foreach (step_text[i])
            want_text.push_back(step_text[i]);
    endfunction

    function void add(logic [7:0] b, logic fin, logic rush = 1'b0);
        byte_q.push_back('{b, fin, 1'b0, rush});
    endfunction

    function void add_hold();
        byte_q.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
    endfunction

    function void add_random_string(logic rush);
        int n;
        int r;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                add(8'($urandom_range(32, 126)), 1'b0, rush);
            else if (r < 50)
                case ($urandom_range(0, 2))
                    0:       add(8'h22, 1'b0, rush);
                    1:       add(8'h5C, 1'b0, rush);
                    default: add(8'($urandom_range(0, 31)), 1'b0, rush);
                endcase
            else if (r < 65)
            begin
                add({3'b110, 5'($urandom_range(0, 31))}, 1'b0, rush);
                add({2'b10, 6'($urandom_range(0, 63))}, 1'b0, rush);
            end
            else if (r < 80)
            begin
                add({4'b1110, 4'($urandom_range(0, 15))}, 1'b0, rush);
                add({2'b10, 6'($urandom_range(0, 63))}, 1'b0, rush);
                add({2'b10, 6'($urandom_range(0, 63))}, 1'b0, rush);
            end
            else if (r < 85)
                add({3'b110, 5'($urandom_range(0, 31))}, 1'b0, rush);
            else if (r < 89)
            begin
                add({4'b1110, 4'($urandom_range(0, 15))}, 1'b0, rush);
                if ($urandom_range(0, 1))
                    add({2'b10, 6'($urandom_range(0, 63))}, 1'b0, rush);
            end
            else if (r < 94)
                add(8'($urandom_range(8'h80, 8'hBF)), 1'b0, rush);
            else
                add(8'($urandom_range(0, 255)), 1'b0, rush);
        end
        byte_q[byte_q.size()-1].fin = 1'b1;
    endfunction

    function void report(string what, txt_t want, txt_t got);
        if (errors < 10)
            $display({"%0t: %s: expected char %02h last %0b end %0b,",
                      " got char %02h last %0b end %0b"},
                     $realtime, what, want.ch, want.last, want.fin, got.ch, got.last, got.fin);
        errors++;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic nxt_push;
        byte_item_t cur;
        if (!rst_n)
        begin
            push       <= 1'b0;
            in_byte    <= 8'h00;
            string_end <= 1'b0;
        end
        else
        begin
            nxt_push = push;
            if (push && !full)
            begin
                escape_predict(in_byte, string_end);
                bytes_sent++;
                if (string_end)
                    strings_sent++;
                nxt_push = 1'b0;
            end
            if (!nxt_push)
            begin
                if (holding)
                begin
                    if (want_text.size() == 0)
                    begin
                        if (settle > 0)
                            settle--;
                        else
                        begin
                            holding = 1'b0;
                            holds_done++;
                        end
                    end
                end
                else if (send_gap > 0)
                    send_gap--;
                else if (byte_q.size() > 0)
                begin
                    cur = byte_q.pop_front();
                    if (cur.hold)
                    begin
                        holding = 1'b1;
                        settle  = HOLD_SETTLE;
                    end
                    else
                    begin
                        in_byte    <= cur.b;
                        string_end <= cur.fin;
                        nxt_push   = 1'b1;
                        send_gap   = cur.rush ? 0 : draw_gap();
                    end
                end
            end
            push <= nxt_push;
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : collect
        txt_t got;
        txt_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                got = '{out_char, run_last, text_end};
                chars_seen++;
                if (want_text.size() == 0)
                    report("unexpected transaction", '0, got);
                else
                begin
                    want = want_text.pop_front();
                    if (got !== want)
                        report("mismatch", want, got);
                end
                if ($urandom_range(0, 63) == 0)
                    pop_rush = !pop_rush;
                pop_gap = pop_rush ? 0 : draw_gap();
            end
            if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall = 0;
            else if (push || holding || byte_q.size() > 0 || want_text.size() > 0)
            begin
                stall++;
                if (stall >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: watchdog expired, %0d characters outstanding",
                             $realtime, want_text.size());
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int count;
        // printable extremes, control escapes and hex escapes
        add(8'h20, 1'b0); add(8'h7E, 1'b0); add(8'h7F, 1'b0); add(8'h00, 1'b0);
        add(8'h22, 1'b0); add(8'h5C, 1'b0); add(8'h08, 1'b0); add(8'h0C, 1'b0);
        add(8'h0A, 1'b0); add(8'h0D, 1'b0); add(8'h09, 1'b1);
        // overlong nul, two- and three-byte maxima
        add(8'hC0, 1'b0); add(8'h80, 1'b0); add(8'hDF, 1'b0); add(8'hBF, 1'b0);
        add(8'hEF, 1'b0); add(8'hBF, 1'b0); add(8'hBF, 1'b1);
        // bad leads and broken sequences
        add(8'hFF, 1'b0); add(8'h80, 1'b0); add(8'hC3, 1'b0); add(8'h41, 1'b1);
        // flush of a held pair plus a new held lead at the end of the string
        add(8'hE2, 1'b0); add(8'h82, 1'b0); add(8'hE2, 1'b1);
        add(8'hC3, 1'b1);
        add_hold();

        count = 0;
        while (count < RANDOM_BYTES)
        begin
            int before_sz;
            before_sz = byte_q.size();
            if (count > 100 && count < 160)
                add_random_string(1'b1);
            else
                add_random_string(1'b0);
            if ($urandom_range(0, 19) == 0)
            begin
                add(8'hC5, 1'b0);
                add_hold();
                add(8'hA0, 1'b1);
            end
            if ($urandom_range(0, 29) == 0)
                add_hold();
            count += byte_q.size() - before_sz;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (byte_q.size() == 0 && !push && !holding && want_text.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (want_text.size() != 0)
            errors++;

        $display("sent %0d bytes in %0d strings through %0d drain pauses",
                 bytes_sent, strings_sent, holds_done);
        $display("checked %0d escaped characters, at most %0d from one byte, %0d errors",
                 chars_seen, max_step, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mu8je_pkg.sv
sv/mu8je_front.sv
sv/mu8je_fifo.sv
sv/mu8je_back.sv
sv/modified_utf8_to_json_escape.sv
dv/tb.sv
